FILE: sv/nxp_pkg.sv
// Shared types and constants for the nixie multiplex / PWM timer.
package nxp_pkg;

  localparam int NUM_DIGITS       = 4;
  localparam int SCAN_W           = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int EDGES_PER_SECOND = 1024;
  localparam int EDGE_W           = $clog2(EDGES_PER_SECOND);

  localparam logic [15:0] PERIOD_RST = 16'd100;
  localparam logic [15:0] DUTY_RST   = 16'd0;
  localparam logic [7:0]  LIT_RST    = 8'd80;
  localparam logic [7:0]  DARK_RST   = 8'd40;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_MSEDGE = 2'd1,
    OP_WRITE  = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    REG_PWM_PERIOD = 2'd0,
    REG_PWM_DUTY   = 2'd1,
    REG_LIT_TICKS  = 2'd2,
    REG_DARK_TICKS = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] pwm_period;
    logic [15:0] pwm_duty;
    logic [7:0]  lit_ticks;
    logic [7:0]  dark_ticks;
  } cfg_t;

endpackage

FILE: sv/nxp_pwm.sv
// Software PWM counters, advanced on each timer tick.
module nxp_pwm (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          tick_i,
  input  nxp_pkg::cfg_t cfg_i,
  output logic          level_d_o
);
  import nxp_pkg::*;

  logic        level_q, level_d;
  logic [15:0] period_cnt_q, period_cnt_d;
  logic [15:0] duty_cnt_q, duty_cnt_d;
  logic [15:0] period_eff;
  logic [15:0] period_dec;
  logic [15:0] duty_dec;

  assign period_eff = (cfg_i.pwm_period == 16'd0) ? 16'd1 : cfg_i.pwm_period;
  assign period_dec = period_cnt_q - 16'd1;
  assign duty_dec   = duty_cnt_q - 16'd1;

  always_comb begin
    level_d      = level_q;
    period_cnt_d = period_cnt_q;
    duty_cnt_d   = duty_cnt_q;
    if (tick_i) begin
      period_cnt_d = period_dec;
      if (period_dec == 16'd0) begin
        // new period: reload, and with nonzero duty restart the high phase (zero duty: low)
        period_cnt_d = period_eff;
        if (cfg_i.pwm_duty == 16'd0) begin
          level_d = 1'b0;
        end else begin
          level_d    = 1'b1;
          duty_cnt_d = cfg_i.pwm_duty;
        end
      end else if (level_q && (cfg_i.pwm_duty < period_eff)) begin
        duty_cnt_d = duty_dec;
        if (duty_dec == 16'd0) begin
          level_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q      <= 1'b0;
      period_cnt_q <= 16'd1;
      duty_cnt_q   <= 16'd0;
    end else begin
      level_q      <= level_d;
      period_cnt_q <= period_cnt_d;
      duty_cnt_q   <= duty_cnt_d;
    end
  end

  assign level_d_o = level_d;

endmodule

FILE: sv/nxp_scan.sv
// Digit store and multiplex scanner with lit and dark phases.
module nxp_scan (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      tick_i,
  input  logic                      wr_i,
  input  logic [1:0]                wr_idx_i,
  input  logic [3:0]                wr_val_i,
  input  nxp_pkg::cfg_t             cfg_i,
  output logic [3:0]                select_d_o,
  output logic [3:0]                bcd_d_o
);
  import nxp_pkg::*;

  logic [3:0]        store_q [NUM_DIGITS];
  logic [7:0]        phase_q, phase_d;
  logic              lit_q, lit_d;
  logic [SCAN_W-1:0] scan_q, scan_d;
  logic [3:0]        sel_q, sel_d;
  logic [3:0]        bcd_q, bcd_d;
  logic [7:0]        phase_dec;
  logic [SCAN_W-1:0] cur_idx;

  assign phase_dec = phase_q - 8'd1;
  assign cur_idx   = (32'(scan_q) < NUM_DIGITS) ? scan_q : '0;

  always_comb begin
    phase_d = phase_q;
    lit_d   = lit_q;
    scan_d  = scan_q;
    sel_d   = sel_q;
    bcd_d   = bcd_q;
    if (tick_i) begin
      phase_d = phase_dec;
      if (phase_dec == 8'd0) begin
        if (lit_q) begin
          // blank between digits
          sel_d   = 4'b0000;
          lit_d   = 1'b0;
          phase_d = (cfg_i.dark_ticks == 8'd0) ? 8'd1 : cfg_i.dark_ticks;
        end else begin
          sel_d   = (32'(cur_idx) < 4) ? (4'b0001 << cur_idx) : 4'b0000;
          bcd_d   = store_q[cur_idx];
          scan_d  = (32'(cur_idx) + 1 >= NUM_DIGITS) ? '0 : cur_idx + 1'b1;
          lit_d   = 1'b1;
          phase_d = (cfg_i.lit_ticks == 8'd0) ? 8'd1 : cfg_i.lit_ticks;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= LIT_RST;
      lit_q   <= 1'b1;
      scan_q  <= '0;
      sel_q   <= 4'b0000;
      bcd_q   <= 4'b0000;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        store_q[SCAN_W'(i)] <= 4'b0000;
      end
    end else begin
      phase_q <= phase_d;
      lit_q   <= lit_d;
      scan_q  <= scan_d;
      sel_q   <= sel_d;
      bcd_q   <= bcd_d;
      if (wr_i && (32'(wr_idx_i) < NUM_DIGITS)) begin
        store_q[SCAN_W'(wr_idx_i)] <= wr_val_i;
      end
    end
  end

  assign select_d_o = sel_d;
  assign bcd_d_o    = bcd_d;

endmodule

FILE: sv/nixie_multiplex_pwm_timer.sv
// Top level: event input stage, config registers, PWM, scanner, result stage.
// A word accepted into the input stage moves to the result stage once that stage is empty
//   or being emptied; the result stage drives the result port.
// Throughput: one event word per cycle while the receiver takes every result word; the
//   input stage refills in the same cycle that it hands its word to the result stage.
// Reset (rst_ni low, async): config returns to period 100, duty 0, lit 80, dark 40;
//   counters and flags reset; digit store and both stages clear; no result word is pending.
module nixie_multiplex_pwm_timer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // event stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] digit_index, [5:2] digit_value, [7:6] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  // result stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] pwm_level, [4:1] digit_select, [8:5] bcd_out,
                                      // [9] square_wave, [10] second_pulse, [15:11] zero
);
  import nxp_pkg::*;

  // ---------------- configuration registers ----------------
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_period <= PERIOD_RST;
      cfg_q.pwm_duty   <= DUTY_RST;
      cfg_q.lit_ticks  <= LIT_RST;
      cfg_q.dark_ticks <= DARK_RST;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_PWM_PERIOD: cfg_q.pwm_period <= cfg_data_i;
        REG_PWM_DUTY:   cfg_q.pwm_duty   <= cfg_data_i;
        REG_LIT_TICKS:  cfg_q.lit_ticks  <= cfg_data_i[7:0];
        REG_DARK_TICKS: cfg_q.dark_ticks <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // ---------------- input stage ----------------
  logic       in_vld_q;
  logic [1:0] op_q;
  logic [1:0] didx_q;
  logic [3:0] dval_q;
  logic       in_acc;
  logic       adv;      // input word moves into the result stage

  assign adv           = in_vld_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= s_axis_tuser;
      didx_q <= s_axis_tdata[1:0];
      dval_q <= s_axis_tdata[5:2];
    end
  end

  // ---------------- event decode ----------------
  logic tick, msedge, wr;

  always_comb begin
    tick   = 1'b0;
    msedge = 1'b0;
    wr     = 1'b0;
    case (op_q)
      OP_TICK:   tick   = adv;
      OP_MSEDGE: msedge = adv;
      OP_WRITE:  wr     = adv;
      default: ;  // unused code: no state change
    endcase
  end

  // ---------------- PWM and scanner ----------------
  logic       pwm_d;
  logic [3:0] sel_d, bcd_d;

  nxp_pwm u_pwm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (tick),
    .cfg_i     (cfg_q),
    .level_d_o (pwm_d)
  );

  nxp_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick),
    .wr_i       (wr),
    .wr_idx_i   (didx_q),
    .wr_val_i   (dval_q),
    .cfg_i      (cfg_q),
    .select_d_o (sel_d),
    .bcd_d_o    (bcd_d)
  );

  // ---------------- millisecond edge: square wave and second flag ----------------
  logic              sq_q, sq_d;
  logic [EDGE_W-1:0] edge_q, edge_d;
  logic              pulse;

  always_comb begin
    sq_d   = sq_q;
    edge_d = edge_q;
    pulse  = 1'b0;
    if (msedge) begin
      sq_d = ~sq_q;
      if (32'(edge_q) == EDGES_PER_SECOND - 1) begin
        edge_d = '0;
        pulse  = 1'b1;
      end else begin
        edge_d = edge_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q   <= 1'b0;
      edge_q <= '0;
    end else begin
      sq_q   <= sq_d;
      edge_q <= edge_d;
    end
  end

  // ---------------- result stage ----------------
  logic        out_vld_q;
  logic [10:0] res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= {pulse, sq_d, bcd_d, sel_d, pwm_d};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b00000, res_q};

endmodule

FILE: sv/nxp_checker.sv
// Port-level checker for the nixie multiplex / PWM timer, bound to the top level.
module nxp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // at most one digit selected
  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[4:1]))
    else $error("digit select not one-hot");

  // a full second is an even number of toggles, so the square wave is low then
  a_pulse_sq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[10] |-> !m_axis_tdata[9])
    else $error("second flag with square wave high");

  // a fresh result word follows an accepted event that passed the input and result stages
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result word without an accepted event");

endmodule

bind nixie_multiplex_pwm_timer nxp_checker u_nxp_checker (.*);

FILE: tb/tb_top.sv
// Self-checking testbench for the nixie multiplex / PWM timer event stream.
`timescale 1ns / 100ps

module tb_top;
  import nxp_pkg::*;

  // Opcode 3 has no package name: the block holds its state and reports.
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam int RST_CYC   = 10;
  localparam int DRAIN_CYC = 4;        // result word passes the input stage and then the result stage
  localparam int CYC_LIMIT = 300000;   // a run past this limit stops and reports mismatches
  localparam int RAND_BLKS = 8;
  localparam int BLK_WORDS = 185;

  // One event word as the sender holds it.
  typedef struct packed {
    logic [1:0] op;
    logic [1:0] idx;
    logic [3:0] val;
  } nixie_ev_t;

  // One display result word, fields in port order.
  typedef struct packed {
    logic       pwm;
    logic [3:0] sel;
    logic [3:0] bcd;
    logic       sq;
    logic       pulse;
  } disp_word_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [1:0] digit_index, [5:2] digit_value, [7:6] zero
  logic [1:0]  s_axis_tuser  = '0;   // [1:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [0] pwm_level, [4:1] digit_select, [8:5] bcd_out,
                                     // [9] square_wave, [10] second_pulse, [15:11] zero

  nixie_multiplex_pwm_timer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: config and state, at reset values.
  // ---------------------------------------------------------------------------
  logic [15:0] sh_period = PERIOD_RST;
  logic [15:0] sh_duty   = DUTY_RST;
  logic [7:0]  sh_lit    = LIT_RST;
  logic [7:0]  sh_dark   = DARK_RST;

  logic        pwm_q      = 1'b0;
  logic [15:0] per_cnt    = 16'd1;
  logic [15:0] duty_cnt   = 16'd0;
  logic [7:0]  phase_cnt  = LIT_RST;
  logic        blank_next = 1'b1;     // next phase expiry blanks the selects
  int          scan_idx   = 0;
  logic [3:0]  digit_mem [NUM_DIGITS];
  logic [3:0]  sel_q      = '0;
  logic [3:0]  bcd_q      = '0;
  logic        sq_q       = 1'b0;
  int          edge_cnt   = 0;

  nixie_ev_t   ev_pend_q[$];    // words waiting for the driver
  disp_word_t  disp_due_q[$];   // predicted result words, oldest first
  disp_word_t  mon_word;

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int err_cnt      = 0;
  int cyc_cnt      = 0;
  logic ev_taken   = 1'b0;      // driver's word was accepted at the last rising edge

  initial begin
    for (int i = 0; i < NUM_DIGITS; i++) digit_mem[SCAN_W'(i)] = '0;
  end

  // Advance the shadow state by one accepted event word and queue its result.
  task automatic predict_disp(input logic [1:0] op, input logic [1:0] didx,
                              input logic [3:0] dval);
    logic [15:0] per_eff;
    logic        pulse;
    int          idx;
    pulse   = 1'b0;
    per_eff = (sh_period == 16'd0) ? 16'd1 : sh_period;
    if (op == OP_TICK) begin
      // PWM: reload at end of period, else count down the duty while high
      per_cnt = per_cnt - 16'd1;
      if (per_cnt == 16'd0) begin
        per_cnt = per_eff;
        if (sh_duty == 16'd0) begin
          pwm_q = 1'b0;
        end else begin
          pwm_q    = 1'b1;
          duty_cnt = sh_duty;
        end
      end else if (pwm_q && sh_duty < per_eff) begin
        duty_cnt = duty_cnt - 16'd1;
        if (duty_cnt == 16'd0) pwm_q = 1'b0;
      end
      // scanner: lit phase, dark phase, next digit
      phase_cnt = phase_cnt - 8'd1;
      if (phase_cnt == 8'd0) begin
        if (blank_next) begin
          sel_q      = '0;
          blank_next = 1'b0;
          phase_cnt  = (sh_dark == 8'd0) ? 8'd1 : sh_dark;
        end else begin
          idx        = (scan_idx < NUM_DIGITS) ? scan_idx : 0;
          sel_q      = (idx < 4) ? (4'd1 << idx) : 4'd0;
          bcd_q      = digit_mem[SCAN_W'(idx)];
          scan_idx   = (idx + 1 >= NUM_DIGITS) ? 0 : idx + 1;
          blank_next = 1'b1;
          phase_cnt  = (sh_lit == 8'd0) ? 8'd1 : sh_lit;
        end
      end
    end else if (op == OP_MSEDGE) begin
      sq_q     = ~sq_q;
      edge_cnt = edge_cnt + 1;
      if (edge_cnt >= EDGES_PER_SECOND) begin
        edge_cnt = 0;
        pulse    = 1'b1;
      end
    end else if (op == OP_WRITE) begin
      if (32'(didx) < NUM_DIGITS) digit_mem[didx] = dval;
    end
    disp_due_q.push_back('{pwm: pwm_q, sel: sel_q, bcd: bcd_q, sq: sq_q, pulse: pulse});
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Rising edge: note handshakes, predict accepted words, check result words.
  // Outputs are read here before the block's own edge updates land.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cyc_cnt++;
    ev_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      predict_disp(s_axis_tuser, s_axis_tdata[1:0], s_axis_tdata[5:2]);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (disp_due_q.size() == 0) begin
        $error("result word 0x%04h with no word due", m_axis_tdata);
        err_cnt++;
      end else begin
        mon_word = disp_due_q.pop_front();
        check_field("pwm_level",    int'(mon_word.pwm),   int'(m_axis_tdata[0]));
        check_field("digit_select", int'(mon_word.sel),   int'(m_axis_tdata[4:1]));
        check_field("bcd_out",      int'(mon_word.bcd),   int'(m_axis_tdata[8:5]));
        check_field("square_wave",  int'(mon_word.sq),    int'(m_axis_tdata[9]));
        check_field("second_pulse", int'(mon_word.pulse), int'(m_axis_tdata[10]));
      end
    end
    if (cyc_cnt > CYC_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: falling edge. A presented word stays put until accepted; between
  // words the sender idles at random.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (s_axis_tvalid && ev_taken) void'(ev_pend_q.pop_front());
    if (!s_axis_tvalid || ev_taken) begin
      if (ev_pend_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= ev_pend_q[0].op;
        s_axis_tdata  <= {2'b00, ev_pend_q[0].val, ev_pend_q[0].idx};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver backpressure, also on the falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_ev(input logic [1:0] op, input logic [1:0] idx, input logic [3:0] val);
    ev_pend_q.push_back('{op: op, idx: idx, val: val});
  endtask

  // Wait until every queued word went in and every result came out, then let
  // the pipeline settle so the block is idle for a register write.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (ev_pend_q.size() != 0 || s_axis_tvalid || disp_due_q.size() != 0);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  // One register write; cfg_valid_i stays high across back-to-back writes.
  task automatic write_reg(input reg_idx_e ridx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= ridx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!(cfg_valid_i && cfg_ready_o));
    case (ridx)
      REG_PWM_PERIOD: sh_period = data;
      REG_PWM_DUTY:   sh_duty   = data;
      REG_LIT_TICKS:  sh_lit    = data[7:0];
      REG_DARK_TICKS: sh_dark   = data[7:0];
      default: ;
    endcase
  endtask

  // Load all four registers; the upper byte of the 8-bit registers is noise.
  task automatic load_cfg(input logic [15:0] per, input logic [15:0] duty,
                          input logic [7:0] lit, input logic [7:0] dark);
    logic [7:0] hi_a;
    logic [7:0] hi_b;
    hi_a = 8'($urandom_range(0, 255));
    hi_b = 8'($urandom_range(0, 255));
    write_reg(REG_PWM_PERIOD, per);
    write_reg(REG_PWM_DUTY,   duty);
    write_reg(REG_LIT_TICKS,  {hi_a, lit});
    write_reg(REG_DARK_TICKS, {hi_b, dark});
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random block: tick-heavy blocks exercise PWM and scanning, edge-heavy ones
  // push the millisecond count toward a full second.
  task automatic gen_block(input int n, input bit edge_heavy);
    int r;
    int edge_pct;
    edge_pct = edge_heavy ? 92 : 20;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < edge_pct)
        push_ev(OP_MSEDGE, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
      else if (r < 96 - (edge_heavy ? 0 : 20))
        push_ev(OP_TICK, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
      else if (r < 98)
        push_ev(OP_WRITE, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
      else
        push_ev(OP_NONE, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] per;
    logic [15:0] duty;
    logic [7:0]  lit;
    logic [7:0]  dark;

    repeat (RST_CYC) @(negedge clk_i);
    rst_ni = 1'b1;

    snd_idle_pct = 11;
    rcv_idle_pct = 71;

    // Directed, reset config: unused opcode, store writes at both value
    // extremes, two millisecond events, then tick events.
    push_ev(OP_NONE,  2'd3, 4'hF);
    push_ev(OP_WRITE, 2'd0, 4'hF);
    push_ev(OP_WRITE, 2'd1, 4'h0);
    push_ev(OP_WRITE, 2'd2, 4'hA);
    push_ev(OP_WRITE, 2'd3, 4'h5);
    push_ev(OP_MSEDGE, 2'd0, 4'h0);
    push_ev(OP_MSEDGE, 2'd3, 4'hF);
    repeat (3) push_ev(OP_TICK, 2'd0, 4'h0);
    wait_idle();

    // Zero period, zero lit and zero dark all act as one: scan every tick.
    load_cfg(16'd0, 16'd1, 8'd0, 8'd0);
    repeat (9) push_ev(OP_TICK, 2'd2, 4'h9);
    wait_idle();

    // Top of every range: duty at the period keeps the output high.
    load_cfg(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    repeat (3) push_ev(OP_TICK, 2'd1, 4'h3);
    push_ev(OP_NONE, 2'd0, 4'h0);
    wait_idle();

    for (int b = 0; b < RAND_BLKS; b++) begin
      if (b < 3) begin
        snd_idle_pct = 11;
        rcv_idle_pct = 71;
      end else if (b < 6) begin
        snd_idle_pct = 71;
        rcv_idle_pct = 11;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      case (b)
        1:       per = 16'd1;
        2:       per = 16'hFFFF;
        4:       per = 16'd0;
        5:       per = 16'($urandom_range(0, 65535));
        3:       per = 16'($urandom_range(2, 40));
        default: per = 16'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 4))
        0:       duty = 16'd0;
        1:       duty = per;
        2:       duty = (per == 16'hFFFF) ? per : per + 16'd1;
        3:       duty = 16'($urandom_range(0, per));
        default: duty = 16'hFFFF;
      endcase
      if (b == 5) duty = 16'($urandom_range(0, 65535));
      if (b == 2) begin
        lit  = 8'hFF;
        dark = 8'hFF;
      end else if (b == 4) begin
        lit  = 8'd0;
        dark = 8'd0;
      end else begin
        lit  = 8'($urandom_range(0, 9));
        dark = 8'($urandom_range(0, 9));
      end
      load_cfg(per, duty, lit, dark);
      gen_block(BLK_WORDS, b[0]);
      // sender holds off here until the block has answered every word
      wait_idle();
    end

    repeat (DRAIN_CYC) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: nixie_multiplex_pwm_timer.f
sv/nxp_pkg.sv
sv/nxp_pwm.sv
sv/nxp_scan.sv
sv/nixie_multiplex_pwm_timer.sv
sv/nxp_checker.sv
tb/tb_top.sv
